// ----- rtl/dth_pkg.sv -----
// Shared types and constants for the detection trigger hold block.
`default_nettype none

package dth_pkg;

   localparam int TimeBits  = 48;
   localparam int ScoreBits = 16;
   localparam int CountBits = 8;
   localparam int TagBits   = 16;
   localparam int DurBits   = 32;
   localparam int CsrBits   = 32;
   localparam int CsrIdxBits = 2;

   localparam logic signed [ScoreBits-1:0] OnThresholdReset  = -16'sd16384;
   localparam logic signed [ScoreBits-1:0] OffThresholdReset = 16'sd16384;

   typedef enum logic {
      OpFeed  = 1'b0,
      OpFlush = 1'b1
   } op_type;

   typedef enum logic [CsrIdxBits-1:0] {
      CsrOnThreshold     = 2'd0,
      CsrOffThreshold    = 2'd1,
      CsrTriggerDuration = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                        operation;
      logic signed [ScoreBits-1:0] score;
      logic [TimeBits-1:0]         pick_time;
      logic [CountBits-1:0]        contributor_count;
      logic [TagBits-1:0]          candidate_tag;
   } req_type;

   typedef struct packed {
      logic signed [ScoreBits-1:0] det_score;
      logic [TimeBits-1:0]         det_pick_time;
      logic [CountBits-1:0]        det_count;
      logic [TagBits-1:0]          det_tag;
      logic                        still_triggered;
   } rsp_type;

   typedef struct packed {
      logic signed [ScoreBits-1:0] on_threshold;
      logic signed [ScoreBits-1:0] off_threshold;
      logic [DurBits-1:0]          trigger_duration;
   } cfg_type;

   typedef struct packed {
      logic                        held_valid;
      logic signed [ScoreBits-1:0] held_score;
      logic [TimeBits-1:0]         held_time;
      logic [CountBits-1:0]        held_count;
      logic [TagBits-1:0]          held_tag;
      logic                        window_open;
      logic [TimeBits:0]           window_end;
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/dth_step.sv -----
// Next-state and emit decision for one candidate or flush.
`default_nettype none

module dth_step import dth_pkg::*; (
   input  req_type   item,
   input  state_type state,
   input  cfg_type   cfg,
   output state_type state_next,
   output logic      emit,
   output rsp_type   det
);

   logic [TimeBits:0] t_ext;
   logic [TimeBits:0] win_new;
   logic              above_on;
   logic              below_off;
   logic              late;
   logic              better;
   logic              differs;
   logic              took;
   logic              expired;
   state_type         a;

   assign t_ext    = {1'b0, item.pick_time};
   assign win_new  = t_ext + {{(TimeBits+1-DurBits){1'b0}}, cfg.trigger_duration};
   assign above_on = item.score > cfg.on_threshold;
   assign below_off = item.score < cfg.off_threshold;
   assign late     = t_ext > state.window_end;
   assign better   = (item.score > state.held_score) &&
                     (item.contributor_count >= state.held_count);

   always_comb begin
      a       = state;
      took    = 1'b0;
      expired = 1'b0;
      emit    = 1'b0;
      differs = 1'b0;
      det     = '0;
      if (item.operation == OpFlush) begin
         emit                = state.held_valid;
         det.det_score       = state.held_score;
         det.det_pick_time   = state.held_time;
         det.det_count       = state.held_count;
         det.det_tag         = state.held_tag;
         det.still_triggered = 1'b0;
         a                   = '0;
      end else begin
         // take an above-on candidate when nothing is held, or an in-window one that beats the held one
         if (above_on) begin
            if (!a.held_valid) begin
               took         = 1'b1;
               a.held_valid = 1'b1;
               a.held_score = item.score;
               a.held_time  = item.pick_time;
               a.held_count = item.contributor_count;
               a.held_tag   = item.candidate_tag;
               if (cfg.trigger_duration != '0) begin
                  a.window_open = 1'b1;
                  a.window_end  = win_new;
               end
            end else if (a.window_open && !late && better) begin
               took         = 1'b1;
               a.held_score = item.score;
               a.held_time  = item.pick_time;
               a.held_count = item.contributor_count;
               a.held_tag   = item.candidate_tag;
               a.window_end = win_new;
            end
         end

         // a freshly moved window end is never behind the item's own time
         expired = a.window_open && !took && late;
         if (a.window_open && (expired || below_off)) begin
            a.window_open = 1'b0;
            a.window_end  = '0;
         end

         emit              = !a.window_open && a.held_valid;
         det.det_score     = a.held_score;
         det.det_pick_time = a.held_time;
         det.det_count     = a.held_count;
         det.det_tag       = a.held_tag;

         differs = (a.held_score != item.score) || (a.held_time != item.pick_time) ||
                   (a.held_count != item.contributor_count) ||
                   (a.held_tag != item.candidate_tag);

         // re-trigger on the expiring candidate
         if (expired && above_on && a.held_valid && differs) begin
            a.held_valid  = 1'b1;
            a.held_score  = item.score;
            a.held_time   = item.pick_time;
            a.held_count  = item.contributor_count;
            a.held_tag    = item.candidate_tag;
            a.window_open = 1'b1;
            a.window_end  = win_new;
         end

         if (!a.window_open) begin
            a.held_valid = 1'b0;
         end
         det.still_triggered = a.window_open;
      end
      state_next = a;
   end

endmodule

`default_nettype wire

// ----- rtl/detection_trigger_hold.sv -----
// Detection trigger hold: input register, one decision step, result register.
// Throughput: one item per cycle unless the result side stalls; an emitted
// detection is registered, and the held candidate and window update, in the
// same cycle the item leaves the input register, so items can follow back to back.
// Reset (synchronous): configuration returns to its reset values, nothing is held,
// the trigger window is closed and both channel registers are empty.
`default_nettype none

module detection_trigger_hold import dth_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wen,
   input  wire logic [CsrIdxBits-1:0] csr_index,
   input  wire logic [CsrBits-1:0]    csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data
);

   cfg_type   cfg_ff;
   logic      in_valid_ff;
   req_type   in_ff;
   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      emit;
   logic      out_free;
   logic      step_go;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_go   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_threshold     <= OnThresholdReset;
         cfg_ff.off_threshold    <= OffThresholdReset;
         cfg_ff.trigger_duration <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CsrOnThreshold:     cfg_ff.on_threshold     <= csr_wdata[ScoreBits-1:0];
            CsrOffThreshold:    cfg_ff.off_threshold    <= csr_wdata[ScoreBits-1:0];
            CsrTriggerDuration: cfg_ff.trigger_duration <= csr_wdata[DurBits-1:0];
            default:            ;
         endcase
      end
   end

   dth_step u_step (
      .item       (in_ff),
      .state      (state_ff),
      .cfg        (cfg_ff),
      .state_next (state_in),
      .emit       (emit),
      .det        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_go) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step_go && emit;
      end
      if (step_go && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // a candidate is held exactly while its window is open
   a_held_open: assert property (@(posedge clock) disable iff (reset)
      state_ff.held_valid == state_ff.window_open)
      else $error("held candidate and window state disagree");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      step_go && (in_ff.operation == OpFlush) |=> !state_ff.held_valid && !state_ff.window_open)
      else $error("flush left state behind");

   a_trig_flag: assert property (@(posedge clock) disable iff (reset)
      step_go && emit |=> rsp_valid_ff && (rsp_ff.still_triggered == state_ff.window_open))
      else $error("result trigger flag does not match window state");

endmodule

`default_nettype wire

// ----- dv/tb_detection_trigger_hold.sv -----
// Self-checking testbench for the detection trigger hold block.
module tb_detection_trigger_hold import dth_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WatchdogLimit = 3000;
   localparam int unsigned SettleCycles  = 4;
   localparam logic [CsrIdxBits-1:0] CsrUnused = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_wen;
   logic [CsrIdxBits-1:0] csr_index;
   logic [CsrBits-1:0]    csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;

   // predictor copy of configuration and hold state
   logic signed [ScoreBits-1:0] on_thr  = OnThresholdReset;
   logic signed [ScoreBits-1:0] off_thr = OffThresholdReset;
   logic [DurBits-1:0]          dur     = '0;

   logic                        held_valid  = 1'b0;
   logic signed [ScoreBits-1:0] held_score  = '0;
   logic [TimeBits-1:0]         held_time   = '0;
   logic [CountBits-1:0]        held_count  = '0;
   logic [TagBits-1:0]          held_tag    = '0;
   logic                        window_open = 1'b0;
   logic [TimeBits:0]           window_end  = '0;

   rsp_type             expected_dets[$];
   int unsigned         failures = 0;
   int unsigned         idle_cycles;
   bit                  no_gaps = 1'b0;
   logic [TimeBits-1:0] now;

   detection_trigger_hold uut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void take_held(input logic signed [ScoreBits-1:0] s,
                                     input logic [TimeBits-1:0] t,
                                     input logic [CountBits-1:0] c,
                                     input logic [TagBits-1:0] g);
      held_valid = 1'b1;
      held_score = s;
      held_time  = t;
      held_count = c;
      held_tag   = g;
   endfunction

   function automatic void drop_held();
      held_valid = 1'b0;
      held_score = '0;
      held_time  = '0;
      held_count = '0;
      held_tag   = '0;
   endfunction

   // Advance the hold state by one item; return 1 when a detection is emitted.
   function automatic bit trigger_step(input req_type item, output rsp_type det);
      logic signed [ScoreBits-1:0] s;
      logic [TimeBits-1:0]         t;
      logic [CountBits-1:0]        c;
      logic [TagBits-1:0]          g;
      bit                          above_on;
      bit                          expired;
      bit                          emit;
      det = '0;
      if (item.operation == OpFlush) begin
         emit = held_valid;
         det.det_score     = held_score;
         det.det_pick_time = held_time;
         det.det_count     = held_count;
         det.det_tag       = held_tag;
         drop_held();
         window_open = 1'b0;
         window_end  = '0;
         return emit;
      end
      s = item.score;
      t = item.pick_time;
      c = item.contributor_count;
      g = item.candidate_tag;
      above_on = s > on_thr;
      if (above_on) begin
         if (!held_valid) begin
            take_held(s, t, c, g);
            if (dur != 0) begin
               window_open = 1'b1;
               window_end  = {1'b0, t} + dur;
            end
         end else if (window_open && {1'b0, t} <= window_end &&
                      s > held_score && c >= held_count) begin
            take_held(s, t, c, g);
            window_end = {1'b0, t} + dur;
         end
      end
      expired = 1'b0;
      if (window_open) begin
         expired = {1'b0, t} > window_end;
         if (expired || s < off_thr) begin
            window_open = 1'b0;
            window_end  = '0;
         end
      end
      det.det_score     = held_score;
      det.det_pick_time = held_time;
      det.det_count     = held_count;
      det.det_tag       = held_tag;
      emit = !window_open && held_valid;
      // a differing candidate on expiry starts a fresh window
      if (expired && above_on && held_valid &&
          (held_score != s || held_time != t || held_count != c || held_tag != g)) begin
         take_held(s, t, c, g);
         window_open = 1'b1;
         window_end  = {1'b0, t} + dur;
      end
      if (!window_open) drop_held();
      det.still_triggered = window_open;
      return emit;
   endfunction

   function automatic int unsigned gap_len();
      int unsigned r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type cand(input int sc, input logic [TimeBits-1:0] t,
                                    input int c, input int g);
      req_type item;
      item.operation         = OpFeed;
      item.score             = sc[ScoreBits-1:0];
      item.pick_time         = t;
      item.contributor_count = c[CountBits-1:0];
      item.candidate_tag     = g[TagBits-1:0];
      return item;
   endfunction

   function automatic req_type flush_item();
      req_type item;
      item.operation         = OpFlush;
      item.score             = 16'($urandom);
      item.pick_time         = {16'($urandom), 32'($urandom)};
      item.contributor_count = 8'($urandom);
      item.candidate_tag     = 16'($urandom);
      return item;
   endfunction

   // Well-formed candidate around the current thresholds and window length,
   // with some flushes and unrelated noise mixed in.
   function automatic req_type next_candidate();
      req_type             item;
      int unsigned         r;
      logic [TimeBits-1:0] step;
      int                  sv;
      r = $urandom_range(0, 99);
      if (r < 8) return flush_item();
      if (r < 14) begin
         item = flush_item();
         item.operation = OpFeed;
         return item;
      end
      item.operation = OpFeed;
      r = $urandom_range(0, 9);
      if (r < 6) step = 48'($urandom_range(0, dur / 4 + 2));
      else if (r < 8) step = 48'(dur) + 48'($urandom_range(1, 50));
      else step = '0;
      if (r == 9 && now > 200) now = now - 48'($urandom_range(1, 200));
      else now = now + step;
      if (now > 48'hFFFF_0000_0000) now = 48'($urandom);
      item.pick_time = now;
      case ($urandom_range(0, 9))
         0: sv = int'(on_thr);
         1: sv = int'(off_thr);
         2: sv = off_thr - 1 - int'($urandom_range(0, 800));
         3: sv = int'($urandom);
         default: sv = on_thr + 1 + int'($urandom_range(0, 3000));
      endcase
      item.score = sv[ScoreBits-1:0];
      r = $urandom_range(0, 9);
      if (r < 7) item.contributor_count = 8'($urandom_range(0, 6));
      else if (r < 9) item.contributor_count = 8'($urandom_range(0, 255));
      else item.contributor_count = 8'd255;
      item.candidate_tag = 16'($urandom);
      return item;
   endfunction

   task automatic send_item(input req_type item);
      int unsigned gap;
      rsp_type     det;
      gap = gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (trigger_step(item, det)) expected_dets.push_back(det);
   endtask

   // Drop valid, wait for every expected detection, then let the pipe empty.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_dets.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxBits-1:0] idx,
                            input logic [CsrBits-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (idx)
         CsrOnThreshold:     on_thr  = value[ScoreBits-1:0];
         CsrOffThreshold:    off_thr = value[ScoreBits-1:0];
         CsrTriggerDuration: dur     = value[DurBits-1:0];
         default: ;
      endcase
   endtask

   task automatic test_reset_config();
      req_type item;
      item = cand(-1, 48'hFFFF_FFFF_FFFF, 255, 65535);
      item.operation = OpFlush;
      send_item(item);
      send_item(cand(-16384, '0, 0, 0));
      send_item(cand(-16383, '0, 0, 0));
      send_item(cand(32767, 48'hFFFF_FFFF_FFFF, 255, 65535));
      send_item(cand(-32768, 48'h8000_0000_0000, 128, 32768));
      send_item(cand(16384, 48'd12345, 7, 16'h1234));
      drain();
   endtask

   task automatic test_trigger_window();
      write_csr(CsrOnThreshold, 32'hFFFF_0000);
      write_csr(CsrOffThreshold, 32'h1234_E000);
      write_csr(CsrTriggerDuration, 32'd100);
      write_csr(CsrUnused, 32'h0000_7FFF);
      send_item(cand(1000, 48'd1000, 3, 1));
      send_item(cand(2000, 48'd1050, 3, 2));   // better, replaces
      send_item(cand(3000, 48'd1060, 2, 3));   // fewer contributors
      send_item(cand(2000, 48'd1070, 5, 4));   // equal score
      send_item(cand(100, 48'd1150, 0, 8));    // exactly at window end
      send_item(cand(-9000, 48'd1155, 0, 9));  // below off, closes
      send_item(cand(500, 48'd2000, 1, 5));
      send_item(cand(-8192, 48'd2010, 1, 10)); // exactly at off
      send_item(cand(600, 48'd2200, 1, 6));    // expiry re-triggers
      send_item(cand(-100, 48'd2400, 0, 7));   // expiry, no re-trigger
      send_item(cand(700, 48'd3000, 2, 11));
      send_item(flush_item());
      send_item(flush_item());
      drain();
   endtask

   task automatic test_time_extremes();
      write_csr(CsrOffThreshold, 32'h0000_C000);
      write_csr(CsrTriggerDuration, 32'hFFFF_FFFF);
      send_item(cand(100, 48'hFFFF_FFFF_FFFF, 1, 20));
      send_item(cand(200, 48'hFFFF_FFFF_FFFF, 1, 21));
      send_item(flush_item());
      drain();
   endtask

   task automatic run_phase(input logic signed [ScoreBits-1:0] on_v,
                            input logic signed [ScoreBits-1:0] off_v,
                            input logic [DurBits-1:0] dur_v,
                            input bit quiet, input int count);
      write_csr(CsrOnThreshold, {16'($urandom), on_v});
      write_csr(CsrOffThreshold, {16'($urandom), off_v});
      write_csr(CsrTriggerDuration, dur_v);
      write_csr(CsrUnused, $urandom);
      no_gaps = quiet;
      now = {16'($urandom), 32'($urandom)} >> 1;
      repeat (count) send_item(next_candidate());
      drain();
      no_gaps = 1'b0;
   endtask

   task automatic test_random_traffic();
      int on_r;
      on_r = int'($urandom_range(0, 24000)) - 16384;
      run_phase(16'sd0, -16'sd4000, 32'd200, 1'b0, 140);
      run_phase(16'sd8000, 16'sd8000, 32'd5000, 1'b1, 140);
      run_phase(-16'sd16384, -16'sd16384, 32'hFFFF_FFFF, 1'b0, 140);
      run_phase(16'sd16384, 16'sd16384, 32'd1, 1'b0, 140);
      run_phase(on_r[ScoreBits-1:0], 16'(on_r - int'($urandom_range(0, 8000))),
                $urandom_range(1, 2000), 1'b0, 140);
      run_phase(-16'sd16384, 16'sd16384, 32'd0, 1'b0, 140);
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_wen   <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_trigger_window();
      test_time_extremes();
      test_random_traffic();
      if (failures == 0 && expected_dets.size() == 0) begin
         $display("tb_detection_trigger_hold passed");
      end else begin
         $display("tb_detection_trigger_hold failed");
      end
      $finish;
   end

   // Result side: random stall, compare each transfer with the oldest expectation.
   initial begin
      rsp_type     got;
      rsp_type     want;
      int unsigned stall_left;
      rsp_stall <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got = rsp_data;
            if (expected_dets.size() == 0) begin
               $error("unexpected detection: tag %0h pick time %0d", got.det_tag,
                      got.det_pick_time);
               failures++;
            end else begin
               want = expected_dets.pop_front();
               if (got.det_score !== want.det_score) begin
                  $error("det_score: expected %0d, got %0d", want.det_score, got.det_score);
                  failures++;
               end
               if (got.det_pick_time !== want.det_pick_time) begin
                  $error("det_pick_time: expected %0d, got %0d", want.det_pick_time,
                         got.det_pick_time);
                  failures++;
               end
               if (got.det_count !== want.det_count) begin
                  $error("det_count: expected %0d, got %0d", want.det_count, got.det_count);
                  failures++;
               end
               if (got.det_tag !== want.det_tag) begin
                  $error("det_tag: expected %0h, got %0h", want.det_tag, got.det_tag);
                  failures++;
               end
               if (got.still_triggered !== want.still_triggered) begin
                  $error("still_triggered: expected %0b, got %0b", want.still_triggered,
                         got.still_triggered);
                  failures++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = gap_len();
         end
      end
   end

   // Stop the run when no transfer happens on either side for too long.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tb_detection_trigger_hold failed");
      $finish;
   end

endmodule
